>>> hdl/kdlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants of the key debouncer: event codes, register
// indexes, configuration bundle and the per-key event record.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    // Field widths
    localparam int unsigned FILTER_W = 8;
    localparam int unsigned LONG_W   = 16;
    localparam int unsigned LCNT_W   = 17;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned DATA_W   = 16;
    localparam int unsigned REG_W    = 2;

    // Saturation value of the long counter
    localparam logic [LCNT_W-1:0] LCNT_MAX = {LCNT_W{1'b1}};

    // Register indexes
    localparam logic [REG_W-1:0] REG_FILTER_TIME   = 2'd0;
    localparam logic [REG_W-1:0] REG_LONG_TIME     = 2'd1;
    localparam logic [REG_W-1:0] REG_PRESSED_LEVEL = 2'd2;

    // Reset values of the registers
    localparam logic [FILTER_W-1:0] FILTER_TIME_RST = 8'd10;
    localparam logic [LONG_W-1:0]   LONG_TIME_RST   = 16'd1000;

    // Event codes
    typedef enum logic [1:0] {
        EV_DOWN = 2'd0,
        EV_UP   = 2'd1,
        EV_LONG = 2'd2
    } t_event;

    // Configuration seen by every lane
    typedef struct packed {
        logic [FILTER_W-1:0] filter_time;
        logic [LONG_W-1:0]   long_time;
    } t_cfg;

    // What one lane found for the current tick
    typedef struct packed {
        logic   fire;
        t_event code;
    } t_lane_evt;

endpackage : kdlp_pkg
`default_nettype wire

>>> hdl/kdlp_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdlp_lane
// One key: up/down integrating filter, pressed flag and saturating long
// counter. Reports the event of the offered tick and commits on step.
// ----------------------------------------------------------------------------
module kdlp_lane
    import kdlp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire logic      i_down,
    input  wire t_cfg      i_cfg,
    output t_lane_evt      o_evt
);

    logic [FILTER_W-1:0] r_fcnt, n_fcnt;
    logic                r_pflag, n_pflag;
    logic [LCNT_W-1:0]   r_lcnt, n_lcnt;

    // Work out next state and event of this tick
    always_comb begin
        n_fcnt     = r_fcnt;
        n_pflag    = r_pflag;
        n_lcnt     = r_lcnt;
        o_evt.fire = 1'b0;
        o_evt.code = EV_DOWN;
        if (i_down) begin
            if (r_fcnt < i_cfg.filter_time) begin
                n_fcnt = r_fcnt + 1'b1;
            end else if (!r_pflag) begin
                n_pflag    = 1'b1;
                o_evt.fire = 1'b1;
                o_evt.code = EV_DOWN;
            end else begin
                // long event fires once, counter saturates past any long_time
                if (r_lcnt == {1'b0, i_cfg.long_time}) begin
                    o_evt.fire = 1'b1;
                    o_evt.code = EV_LONG;
                end
                if (r_lcnt != LCNT_MAX) begin
                    n_lcnt = r_lcnt + 1'b1;
                end
            end
        end else begin
            if (r_fcnt != '0) begin
                n_fcnt = r_fcnt - 1'b1;
            end else begin
                n_lcnt = '0;
                if (r_pflag) begin
                    n_pflag    = 1'b0;
                    o_evt.fire = 1'b1;
                    o_evt.code = EV_UP;
                end
            end
        end
    end

    // Commit on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt  <= '0;
            r_pflag <= 1'b0;
            r_lcnt  <= '0;
        end else if (i_step) begin
            r_fcnt  <= n_fcnt;
            r_pflag <= n_pflag;
            r_lcnt  <= n_lcnt;
        end
    end

endmodule : kdlp_lane
`default_nettype wire

>>> hdl/kdlp_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdlp_merge
// Collects one tick's events from all lanes and hands them out one item
// per cycle unless stalled, in key order via an output register, last marked.
// ----------------------------------------------------------------------------
module kdlp_merge
    import kdlp_pkg::*;
#(
    parameter int unsigned NUM_KEYS = 3
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire t_lane_evt           i_evt [NUM_KEYS],
    output logic                     o_can_load,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [IDX_W-1:0]         o_key_index,
    output logic [1:0]               o_event_res,
    output logic                     o_last
);

    localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int unsigned EW = (KW > IDX_W) ? KW : IDX_W;

    logic [NUM_KEYS-1:0] r_mask, n_mask;
    t_event              r_code [NUM_KEYS];
    logic                r_valid;
    logic [IDX_W-1:0]    r_key;
    t_event              r_ev;
    logic                r_last;

    logic [KW-1:0]       pick;
    logic [EW-1:0]       pick_ext;
    logic [NUM_KEYS-1:0] rest;
    logic                out_free;
    logic                move;

    // Find the lowest pending key
    always_comb begin
        pick = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                pick = KW'(k);
            end
        end
    end

    assign pick_ext   = EW'(pick);
    assign rest       = r_mask & (r_mask - 1'b1);
    assign out_free   = !r_valid || i_ready;
    assign move       = (r_mask != '0) && out_free;
    assign o_can_load = (r_mask == '0) || (move && (rest == '0));

    // Drop the moved key, take a fresh tick when the buffer drains
    always_comb begin
        n_mask = r_mask;
        if (move) begin
            n_mask = rest;
        end
        if (i_load) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                n_mask[k] = i_evt[k].fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (move) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the event codes of the buffered tick
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_code[k] <= i_evt[k].code;
            end
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_key  <= pick_ext[IDX_W-1:0];
            r_ev   <= r_code[pick];
            r_last <= (rest == '0);
        end
    end

    assign o_valid     = r_valid;
    assign o_key_index = r_key;
    assign o_event_res = r_ev;
    assign o_last      = r_last;

endmodule : kdlp_merge
`default_nettype wire

>>> hdl/key_debounce_long_press.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_debounce_long_press
// Debounces NUM_KEYS push buttons and reports down, up and long-press items.
// ----------------------------------------------------------------------------
// Each input item is one scan tick with the raw pin level of every key. All
// keys are filtered in parallel lanes in the cycle the tick is accepted, and
// the events found are queued and sent in key order, one result item per
// cycle while i_ready allows, with o_last set on the final event of the tick.
// The next tick is taken in the cycle the last queued event moves into the
// output register, so the single result register limits the tick rate.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata
// while the block is idle; the key index is reported modulo 4.
// ----------------------------------------------------------------------------
module key_debounce_long_press
    import kdlp_pkg::*;
#(
    parameter int unsigned NUM_KEYS = 3
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [REG_W-1:0]    i_cfg_index,
    input  wire logic [DATA_W-1:0]   i_cfg_wdata,
    // scan ticks
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [NUM_KEYS-1:0] i_key_levels,
    // events
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [IDX_W-1:0]         o_key_index,
    output logic [1:0]               o_event_res,
    output logic                     o_last
);

    logic [FILTER_W-1:0] r_filter_time;
    logic [LONG_W-1:0]   r_long_time;
    logic                r_pressed_level;

    t_cfg                cfg;
    t_lane_evt           lane_evt [NUM_KEYS];
    logic [NUM_KEYS-1:0] key_down;
    logic [NUM_KEYS-1:0] fire_vec;
    logic [NUM_KEYS-1:0] up_vec;
    logic [NUM_KEYS-1:0] hold_vec;
    logic                accept;
    logic                can_load;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_time   <= FILTER_TIME_RST;
            r_long_time     <= LONG_TIME_RST;
            r_pressed_level <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FILTER_TIME:   r_filter_time   <= i_cfg_wdata[FILTER_W-1:0];
                REG_LONG_TIME:     r_long_time     <= i_cfg_wdata[LONG_W-1:0];
                REG_PRESSED_LEVEL: r_pressed_level <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg.filter_time = r_filter_time;
    assign cfg.long_time   = r_long_time;

    assign o_ready = can_load;
    assign accept  = i_valid && can_load;

    // One filter lane per key
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        assign key_down[k] = (i_key_levels[k] == r_pressed_level);
        assign fire_vec[k] = lane_evt[k].fire;
        assign up_vec[k]   = lane_evt[k].fire && (lane_evt[k].code == EV_UP);
        assign hold_vec[k] = lane_evt[k].fire && (lane_evt[k].code != EV_UP);

        kdlp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (accept),
            .i_down  (key_down[k]),
            .i_cfg   (cfg),
            .o_evt   (lane_evt[k])
        );
    end

    // Serialize the tick's events
    kdlp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_evt       (lane_evt),
        .o_can_load  (can_load),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_key_index (o_key_index),
        .o_event_res (o_event_res),
        .o_last      (o_last)
    );

`ifndef NO_ASSERTIONS
    // A release event only comes from a key that reads released
    a_up_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (up_vec & key_down) == '0)
        else $error("up event from a key that reads pressed");

    // Down and long events only come from a key that reads pressed
    a_hold_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hold_vec & ~key_down) == '0)
        else $error("down or long event from a key that reads released");

    // A tick without events leaves the block ready for the next one
    a_quiet_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (fire_vec == '0)) |=> o_ready)
        else $error("not ready after a tick without events");
`endif

endmodule : key_debounce_long_press
`default_nettype wire

>>> verif/tb_key_debounce_long_press.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_debounce_long_press
// Self-checking bench for the three-key debouncer with long-press detection.
// ----------------------------------------------------------------------------
// Scan ticks are sent over the valid/ready input channel while a software
// copy of the per-key integrating filters, pressed flags and long counters
// works out the down, up and long items each tick must produce. Every item
// taken from the result channel is checked field by field against the oldest
// expected one. Directed tests cover reset values, zero filter time, both pin
// polarities, a filter time lowered below the running count, the largest
// register values and output back-pressure; random phases then drive bouncing
// key sequences under several sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_key_debounce_long_press;
    import kdlp_pkg::*;

    localparam int unsigned NKEYS         = 3;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_TICKS  = 80;

    // Index past the last register; writes to it must be ignored
    localparam logic [REG_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] key;
        t_event           code;
        logic             last;
    } t_key_event;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [REG_W-1:0]    i_cfg_index;
    logic [DATA_W-1:0]   i_cfg_wdata;
    logic                i_valid;
    logic                o_ready;
    logic [NKEYS-1:0]    i_key_levels;
    logic                o_valid;
    logic                i_ready;
    logic [IDX_W-1:0]    o_key_index;
    logic [1:0]          o_event_res;
    logic                o_last;

    // Debouncer copy: configuration and per-key state
    logic [FILTER_W-1:0] cfg_filter_time;
    logic [LONG_W-1:0]   cfg_long_time;
    logic                cfg_pressed_level;
    logic [FILTER_W-1:0] filter_cnt [NKEYS];
    logic                key_held   [NKEYS];
    logic [LCNT_W-1:0]   hold_cnt   [NKEYS];

    t_key_event          pending_events[$];
    int unsigned         n_errors;
    int unsigned         send_idle_pct;
    int unsigned         recv_stall_pct;
    int unsigned         recv_pause_cycles;
    int unsigned         quiet_cycles;

    key_debounce_long_press #(
        .NUM_KEYS (NKEYS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_key_levels (i_key_levels),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_key_index  (o_key_index),
        .o_event_res  (o_event_res),
        .o_last       (o_last)
    );

    // Generate the 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the filters by one scan tick and queue the items it causes
    function automatic void debounce_tick(input logic [NKEYS-1:0] levels);
        t_key_event found [NKEYS];
        int         n;
        logic       fire;
        t_event     code;
        n = 0;
        for (int k = 0; k < NKEYS; k++) begin
            fire = 1'b0;
            code = EV_DOWN;
            if (levels[k] == cfg_pressed_level) begin
                if (filter_cnt[k] < cfg_filter_time) begin
                    filter_cnt[k] = filter_cnt[k] + 1'b1;
                end else if (!key_held[k]) begin
                    key_held[k] = 1'b1;
                    fire = 1'b1;
                end else begin
                    if (hold_cnt[k] == {1'b0, cfg_long_time}) begin
                        fire = 1'b1;
                        code = EV_LONG;
                    end
                    if (hold_cnt[k] != LCNT_MAX)
                        hold_cnt[k] = hold_cnt[k] + 1'b1;
                end
            end else if (filter_cnt[k] != '0) begin
                filter_cnt[k] = filter_cnt[k] - 1'b1;
            end else begin
                hold_cnt[k] = '0;
                if (key_held[k]) begin
                    key_held[k] = 1'b0;
                    fire = 1'b1;
                    code = EV_UP;
                end
            end
            if (fire) begin
                found[n] = '{key: IDX_W'(k), code: code, last: 1'b0};
                n++;
            end
        end
        if (n > 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_events.push_back(found[i]);
    endfunction

    // Check each item taken from the result channel
    always @(posedge i_clk) begin
        t_key_event want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected item: key_index %0d event_res %0d last %0d",
                       o_key_index, o_event_res, o_last);
                n_errors++;
            end else begin
                want = pending_events.pop_front();
                if (o_key_index !== want.key) begin
                    $error("key_index: expected %0d, actual %0d", want.key, o_key_index);
                    n_errors++;
                end
                if (o_event_res !== want.code) begin
                    $error("event_res: expected %0d, actual %0d", want.code, o_event_res);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // Drive the receiver ready, with random stalls and requested long pauses
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_pause_cycles != 0) begin
                recv_pause_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one scan tick; entered and left at a falling edge, valid left high
    task automatic send_tick(input logic [NKEYS-1:0] levels);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_key_levels <= levels;
        @(posedge i_clk);
        while (o_ready !== 1'b1)
            @(posedge i_clk);
        debounce_tick(levels);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected item has arrived
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_events.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register and mirror it in the debouncer copy; leaves we high
    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            REG_FILTER_TIME:   cfg_filter_time   = data[FILTER_W-1:0];
            REG_LONG_TIME:     cfg_long_time     = data[LONG_W-1:0];
            REG_PRESSED_LEVEL: cfg_pressed_level = data[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Write all registers once the block is idle, with junk in unused bits
    task automatic configure(input logic [FILTER_W-1:0] ft, input logic [LONG_W-1:0] lt,
                             input logic pl);
        wait_idle();
        write_reg(REG_FILTER_TIME, {8'($urandom), ft});
        write_reg(REG_LONG_TIME, lt);
        write_reg(REG_PRESSED_LEVEL, {15'($urandom), pl});
        write_reg(REG_SPARE, 16'($urandom));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Reset values: active-low pins, filter of ten; all keys down together
    task automatic test_reset_values();
        repeat (11) send_tick(3'b000);
        send_tick(3'b111);
    endtask

    // Zero filter time, active-high pins, at most one long item per hold
    task automatic test_zero_filter_polarity();
        configure(8'd0, 16'd0, 1'b1);
        send_tick(3'b111);
        send_tick(3'b111);
        repeat (11) send_tick(3'b000);
        send_tick(3'b101);
        send_tick(3'b010);
    endtask

    // Largest filter time, then lower it below the running count
    task automatic test_filter_lowered();
        configure(8'd255, 16'd65535, 1'b0);
        repeat (40) send_tick(3'b010);
        configure(8'd3, 16'd2, 1'b0);
        send_tick(3'b000);
        repeat (3) send_tick(3'b111);
        repeat (5) send_tick(3'b000);
        repeat (45) send_tick(3'b111);
    endtask

    // Largest long time: a short hold gives down items and no long item
    task automatic test_long_time_max();
        configure(8'd0, 16'd65535, 1'b1);
        send_tick(3'b000);
        repeat (20) send_tick(3'b111);
        send_tick(3'b000);
    endtask

    // Hold off the receiver so the block fills and stalls its input
    task automatic test_output_backpressure();
        configure(8'd0, 16'd1, 1'b0);
        @(posedge i_clk);
        recv_pause_cycles = 300;
        @(negedge i_clk);
        for (int i = 0; i < 30; i++)
            send_tick((i % 2 == 0) ? 3'b000 : 3'b111);
    endtask

    // Random configuration and bouncing key sequences under one idle pattern
    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        logic [NKEYS-1:0] levels;
        logic             want_down [NKEYS];
        logic             pin;
        configure(8'($urandom_range(0, 4)), 16'($urandom_range(0, 12)),
                  1'($urandom_range(0, 1)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < NKEYS; k++)
            want_down[k] = 1'($urandom_range(0, 1));
        for (int i = 0; i < RANDOM_TICKS; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                levels = NKEYS'($urandom);
            end else begin
                for (int k = 0; k < NKEYS; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        want_down[k] = ~want_down[k];
                    // flip the pin now and then to model contact bounce
                    pin = want_down[k] ^ ($urandom_range(0, 9) == 0);
                    levels[k] = pin ? cfg_pressed_level : ~cfg_pressed_level;
                end
            end
            send_tick(levels);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_wdata       = '0;
        i_valid           = 1'b0;
        i_key_levels      = '0;
        n_errors          = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        recv_pause_cycles = 0;
        quiet_cycles      = 0;
        cfg_filter_time   = FILTER_TIME_RST;
        cfg_long_time     = LONG_TIME_RST;
        cfg_pressed_level = 1'b0;
        for (int k = 0; k < NKEYS; k++) begin
            filter_cnt[k] = '0;
            key_held[k]   = 1'b0;
            hold_cnt[k]   = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_zero_filter_polarity();
        test_filter_lowered();
        test_long_time_max();
        test_output_backpressure();
        test_random_phase(0, 0);
        test_random_phase(75, 0);
        test_random_phase(0, 75);
        test_random_phase(35, 35);

        wait_idle();
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hdl/kdlp_pkg.sv
hdl/kdlp_lane.sv
hdl/kdlp_merge.sv
hdl/key_debounce_long_press.sv
verif/tb_key_debounce_long_press.sv
